// File: hw/rtl/bfa_pkg.sv
// bfa_pkg: shared types and constants of the bitmap frame allocator.
// Operation codes, fixed field widths and the result word layout.
// No dependencies.
`default_nettype none

package bfa_pkg;

  // Fixed field widths
  localparam int ADDR_W    = 25;
  localparam int CNT_W     = 14;
  localparam int CFG_W     = 26;
  localparam int OP_W      = 2;
  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = 5;

  localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_INIT   = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  // Bitmap memory port control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // One result word
  typedef struct packed {
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_frames;
    logic              already_free;
    logic              out_of_memory;
    logic [ADDR_W-1:0] allocated_address;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfa_bitmap_ram.sv
// bfa_bitmap_ram: usage bitmap storage, one write and one read port,
// registered read data. Depends on bfa_pkg.
`default_nettype none

module bfa_bitmap_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                            clk_i,
  input  wire bfa_pkg::mem_ctl_t               ctl_i,
  input  wire logic [AW-1:0]                   rd_addr_i,
  input  wire logic [AW-1:0]                   wr_addr_i,
  input  wire logic [bfa_pkg::WORD_BITS-1:0]   wr_data_i,
  output logic      [bfa_pkg::WORD_BITS-1:0]   rd_data_o
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/bfa_cfg_regs.sv
// bfa_cfg_regs: APB register file holding the reserved end address.
// Depends on bfa_pkg.
`default_nettype none

module bfa_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output logic      [bfa_pkg::CFG_W-1:0]     reserved_end_o
);
  import bfa_pkg::*;

  localparam logic REG_RESERVED_END = 1'b0;

  logic [CFG_W-1:0] reserved_end_q;
  logic             wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_RESERVED_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_end_q <= '0;
    end else if (wr_hit) begin
      reserved_end_q <= pwdata[CFG_W-1:0];
    end
  end

  // Read back; unmapped word reads zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RESERVED_END) begin
      prdata = 32'(reserved_end_q);
    end
  end

  assign reserved_end_o = reserved_end_q;

endmodule

`default_nettype wire

// File: hw/rtl/bfa_engine.sv
// bfa_engine: allocation sequencer. Scans, updates and sweeps the usage
// bitmap held in bfa_bitmap_ram, and keeps the used-frame count.
// Depends on bfa_pkg and bfa_bitmap_ram.
`default_nettype none

module bfa_engine #(
  parameter int FRAME_COUNT = 8192,
  parameter int PAGE_BYTES  = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [bfa_pkg::CFG_W-1:0]     reserved_end_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bfa_pkg::OP_W-1:0]      in_op_i,
  input  wire logic [bfa_pkg::ADDR_W-1:0]    in_addr_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output bfa_pkg::res_t                      res_o
);
  import bfa_pkg::*;

  localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int UW         = $clog2(FRAME_COUNT + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);  // PAGE_BYTES is a power of two
  localparam int FIW        = ADDR_W - PAGE_SHIFT;
  localparam int FIRST_W    = CFG_W + 1 - PAGE_SHIFT;
  localparam int TAIL_BITS  = FRAME_COUNT % WORD_BITS;
  localparam logic [WORD_BITS-1:0] TAIL_MASK = (TAIL_BITS == 0) ? '0 :
      ~((WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1));
  localparam logic [WAW-1:0] LAST_W   = WAW'(WORD_COUNT - 1);
  localparam logic [UW-1:0]  FULL_CNT = UW'(FRAME_COUNT);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FREE  = 6'b001000,
    S_INIT  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [WAW-1:0]       idx_q, idx_d;        // word under work
  logic [UW-1:0]        used_q, used_d;
  logic [FIRST_W-1:0]   first_q, first_d;    // first frame freed by init
  logic [FIW-1:0]       frame_q, frame_d;    // frame named by a free
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic                 oom_q, oom_d;
  logic                 already_q, already_d;

  mem_ctl_t             mem_ctl;
  logic [WAW-1:0]       rd_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_data;

  logic [FIW-1:0]       in_frame;
  logic                 in_frame_ok;
  logic [BIT_IDX_W-1:0] zero_idx;
  logic [63:0]          alloc_full;
  logic [WORD_BITS-1:0] init_word;
  logic [31:0]          idx32;
  logic [31:0]          first_word32;
  logic                 accept;

  bfa_bitmap_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (WAW)
  ) u_ram (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // Lowest clear bit of a word
  function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = BIT_IDX_W'(i);
      end
    end
    return r;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign in_frame    = FIW'(in_addr_i >> PAGE_SHIFT);
  assign in_frame_ok = (32'(in_frame) < 32'(FRAME_COUNT));
  assign zero_idx    = lowest_zero(rd_data);
  assign alloc_full  = 64'({idx_q, zero_idx}) << PAGE_SHIFT;

  // Word written by the init sweep: used below the boundary, tail bits kept used
  assign idx32        = 32'(idx_q);
  assign first_word32 = 32'(first_q >> BIT_IDX_W);
  always_comb begin
    if (idx32 < first_word32) begin
      init_word = ALL_ONES;
    end else if (idx32 == first_word32) begin
      init_word = (WORD_BITS'(1) << first_q[BIT_IDX_W-1:0]) - WORD_BITS'(1);
    end else begin
      init_word = '0;
    end
    if (idx_q == LAST_W) begin
      init_word = init_word | TAIL_MASK;
    end
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    used_d        = used_q;
    first_d       = first_q;
    frame_d       = frame_q;
    addr_d        = addr_q;
    oom_d         = oom_q;
    already_d     = already_q;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    rd_addr       = '0;
    wr_data       = ALL_ONES;

    unique case (state_q)
      S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        idx_d         = idx_q + WAW'(1);
        if (idx_q == LAST_W) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          addr_d    = '0;
          oom_d     = 1'b0;
          already_d = 1'b0;
          frame_d   = in_frame;
          unique case (op_e'(in_op_i))
            OP_ALLOC: begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = '0;
              idx_d         = '0;
              state_d       = S_SCAN;
            end
            OP_FREE: begin
              if (in_frame_ok) begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = WAW'(in_frame >> BIT_IDX_W);
                idx_d         = WAW'(in_frame >> BIT_IDX_W);
                state_d       = S_FREE;
              end else begin
                state_d = S_RESP;
              end
            end
            OP_INIT: begin
              first_d = FIRST_W'(((CFG_W + 1)'(reserved_end_i) +
                                  (CFG_W + 1)'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
              idx_d   = '0;
              state_d = S_INIT;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // rd_data holds word idx_q; the next word is fetched when this one is full
      S_SCAN: begin
        if (rd_data != ALL_ONES) begin
          mem_ctl.wr_en = 1'b1;
          wr_data       = rd_data | (WORD_BITS'(1) << zero_idx);
          used_d        = used_q + UW'(1);
          addr_d        = ADDR_W'(alloc_full);
          state_d       = S_RESP;
        end else if (idx_q == LAST_W) begin
          oom_d   = 1'b1;
          state_d = S_RESP;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_q + WAW'(1);
          idx_d         = idx_q + WAW'(1);
        end
      end

      S_FREE: begin
        if (rd_data[frame_q[BIT_IDX_W-1:0]]) begin
          mem_ctl.wr_en = 1'b1;
          wr_data       = rd_data & ~(WORD_BITS'(1) << frame_q[BIT_IDX_W-1:0]);
          used_d        = used_q - UW'(1);
        end else begin
          already_d = 1'b1;
        end
        state_d = S_RESP;
      end

      S_INIT: begin
        mem_ctl.wr_en = 1'b1;
        wr_data       = init_word;
        idx_d         = idx_q + WAW'(1);
        if (idx_q == LAST_W) begin
          used_d  = (32'(first_q) >= 32'(FRAME_COUNT)) ? FULL_CNT : UW'(first_q);
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      used_q  <= FULL_CNT;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    frame_q   <= frame_d;
    addr_q    <= addr_d;
    oom_q     <= oom_d;
    already_q <= already_d;
  end

  assign res_valid_o             = (state_q == S_RESP);
  assign res_o.allocated_address = addr_q;
  assign res_o.out_of_memory     = oom_q;
  assign res_o.already_free      = already_q;
  assign res_o.free_frames       = CNT_W'(FULL_CNT - used_q);
  assign res_o.used_count        = CNT_W'(used_q);

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= FULL_CNT)
    else $error("used count beyond frame count");

  a_oom_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_of_memory |-> used_q == FULL_CNT)
    else $error("out of memory reported with free frames left");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("bitmap read and write in one cycle");

  a_already_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FREE && !rd_data[frame_q[BIT_IDX_W-1:0]] |-> !mem_ctl.wr_en && used_d == used_q)
    else $error("free of a free frame changed state");

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_frame_allocator_top.sv
// bitmap_frame_allocator_top: bitmap page-frame allocator, top level with
// stream ports, output word register and APB configuration.
// Depends on bfa_pkg, bfa_cfg_regs, bfa_engine, bfa_bitmap_ram.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: operation; tdata: frame_address
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result word
//  apb       in   psel/penable/pwrite/pready   reserved_end_address at byte 0
//
// Alloc reads bitmap words from word 0 up to the first with a clear bit, or
// to the last word when memory is full; the scan reads one bitmap word a cycle.
// Free reads the word, writes it back modified, then gives the result; init
// writes every word in turn (one word written a cycle). One word is worked on at a time.
// After reset a sweep sets every bitmap word to all ones; no word is accepted
// until it ends.
// A result waits in the output register, so the next word is taken while it
// stalls; a second finished result waits in the sequencer.
`default_nettype none

module bitmap_frame_allocator_top #(
  parameter int FRAME_COUNT = 8192,
  parameter int PAGE_BYTES  = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [24:0] frame_address, [31:25] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [24:0] allocated_address, [25] out_of_memory,
                                           // [26] already_free, [40:27] free_frames,
                                           // [54:41] used_count, [55] zero
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bfa_pkg::*;

  logic [CFG_W-1:0] reserved_end;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  bfa_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .reserved_end_o (reserved_end)
  );

  bfa_engine #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .reserved_end_i (reserved_end),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser),
    .in_addr_i      (s_axis_tdata[ADDR_W-1:0]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // Output word register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire
